[sv/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  // contents of one slot
  typedef struct packed {
    logic             occ;
    logic [DataW-1:0] value;
    logic [DataW-1:0] prio;
  } slot_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [DataW-1:0] value;
    logic [DataW-1:0] prio;
  } cell_cmd_t;

endpackage

[sv/spq_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cmd_if
// Request channel: operation code, value and priority.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] value;
  logic signed [31:0] priority_req;

  modport source (output valid, output func, output value, output priority_req,
                  input ready);
  modport sink (input valid, input func, input value, input priority_req,
                output ready);
endinterface

[sv/spq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel: status, head entry and entry count.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               head_valid;
  logic signed [31:0] head_value;
  logic signed [31:0] head_priority;
  logic [4:0]         entry_count;

  modport source (output valid, output status, output head_valid,
                  output head_value, output head_priority, output entry_count,
                  input ready);
  modport sink (input valid, input status, input head_valid,
                input head_value, input head_priority, input entry_count,
                output ready);
endinterface

[sv/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted list: keeps, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                upd,
  input  spq_pkg::cell_cmd_t  cmd,
  input  spq_pkg::slot_t      left,
  input  logic                left_ge,
  input  spq_pkg::slot_t      right,
  input  logic                hit_in,
  output spq_pkg::slot_t      slot,
  output spq_pkg::slot_t      slot_next,
  output logic                ge,
  output logic                hit_out
);
  import spq_pkg::*;

  logic match;

  // entry stays ahead of an insert with this priority
  assign ge      = slot.occ && !($signed(slot.prio) < $signed(cmd.prio));
  assign match   = slot.occ && (slot.value == cmd.value);
  assign hit_out = hit_in || match;

  always_comb begin
    slot_next = slot;
    if (cmd.ins_en) begin
      if (!ge) begin
        if (left_ge) begin
          slot_next.occ   = 1'b1;
          slot_next.value = cmd.value;
          slot_next.prio  = cmd.prio;
        end else begin
          slot_next = left;
        end
      end
    end else if (cmd.del_en && hit_out) begin
      slot_next = right;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      slot <= slot_next;
    end
    if (rst) begin
      slot.occ <= 1'b0;
    end
  end

endmodule

[sv/sorted_priority_queue_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per operation: insert, delete first entry with a
//   given value, or peek (code 3 acts as a peek). rsp returns exactly one
//   word per command with status, head entry after the operation and count.
//   The list lives in DEPTH cells, highest priority in cell 0; equal
//   priorities keep arrival order. An insert or delete is broadcast to all
//   cells and each cell keeps its entry, takes the new one or copies its
//   neighbour, so the whole list moves together in one update.
//   Timing: a command is registered on acceptance; once the result
//   register is free the cells update and the result word is registered
//   at that same edge, which raises rsp.valid. One command is in flight
//   at a time: a new command is not accepted until the held one has
//   executed, as the command register is followed by the cell update.
//   Stall: a waiting result word does not block acceptance of the next
//   command; that command then holds in its register until rsp is free.
//   Reset (synchronous, rst high) empties the queue and clears both valids.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  spq_cmd_if.sink  cmd,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // command register
  logic             busy;
  logic [1:0]       op;
  logic [DataW-1:0] op_value;
  logic [DataW-1:0] op_prio;

  // entry counter
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // result register
  logic             rsp_valid;
  logic [1:0]       status;
  logic             head_valid;
  logic [DataW-1:0] head_value;
  logic [DataW-1:0] head_priority;
  logic [4:0]       entry_count;

  logic          fire;
  logic          full;
  logic          found;
  logic [1:0]    status_next;
  logic [CW+4:0] count_wide;
  cell_cmd_t     ccmd;

  slot_t          cur  [DEPTH];
  slot_t          nxt  [DEPTH];
  logic [DEPTH-1:0] ge;
  logic [DEPTH-1:0] hit;

  // execute when a command is held and the result register is free
  assign fire      = busy && (!rsp_valid || rsp.ready);
  assign cmd.ready = !busy;

  assign full  = (count == CW'(DEPTH));
  assign found = hit[DEPTH-1];

  assign ccmd.ins_en = (op == OP_INSERT) && !full;
  assign ccmd.del_en = (op == OP_DELETE);
  assign ccmd.value  = op_value;
  assign ccmd.prio   = op_prio;

  // row of cells: left neighbour feeds inserts, right neighbour feeds deletes
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_ge;
    logic  hit_in;

    if (i == 0) begin : g_first
      assign left_s  = '0;
      assign left_ge = 1'b1;
      assign hit_in  = 1'b0;
    end else begin : g_mid
      assign left_s  = cur[i-1];
      assign left_ge = ge[i-1];
      assign hit_in  = hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = cur[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .upd       (fire),
      .cmd       (ccmd),
      .left      (left_s),
      .left_ge   (left_ge),
      .right     (right_s),
      .hit_in    (hit_in),
      .slot      (cur[i]),
      .slot_next (nxt[i]),
      .ge        (ge[i]),
      .hit_out   (hit[i])
    );
  end

  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // count field carries the low bits of the count
  assign count_wide = (CW+5)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      // hold a new command
      if (cmd.valid && cmd.ready) begin
        busy     <= 1'b1;
        op       <= cmd.func;
        op_value <= cmd.value;
        op_prio  <= cmd.priority_req;
      end else if (fire) begin
        busy <= 1'b0;
      end

      // advance the result word, drop it once taken
      if (fire) begin
        rsp_valid     <= 1'b1;
        count         <= count_next;
        status        <= status_next;
        head_valid    <= nxt[0].occ;
        head_value    <= nxt[0].occ ? nxt[0].value : '0;
        head_priority <= nxt[0].occ ? nxt[0].prio : '0;
        entry_count   <= count_wide[4:0];
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = status;
  assign rsp.head_valid    = head_valid;
  assign rsp.head_value    = head_value;
  assign rsp.head_priority = head_priority;
  assign rsp.entry_count   = entry_count;

endmodule
